### hdl/chs_pkg.sv
// Shared types, constants and the CRC-32 function for the container header scanner.
// Used by chs_judge and container_header_scanner; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

    localparam int HDR_BYTES    = 28;
    localparam int CRC_SPAN     = 24;
    localparam int FOOTER_BYTES = 8;
    localparam int MAGIC_BYTES  = 8;

    // Field offsets inside the header.
    localparam int VERSION_AT = 8;
    localparam int HSIZE_AT   = 10;
    localparam int FLAGS_AT   = 12;
    localparam int TOTAL_AT   = 16;
    localparam int CRC_AT     = 24;

    localparam logic [15:0] HDR_VERSION = 16'd1;
    localparam logic [31:0] LEAST_TOTAL = 32'(HDR_BYTES + FOOTER_BYTES);
    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAGIC     = 2'd0;
    localparam logic [1:0] REG_IMAGE_LEN = 2'd1;
    localparam logic [1:0] REG_SIZE_CAP  = 2'd2;

    localparam logic [31:0] SIZE_CAP_RESET = 32'd16777216;

    typedef logic [1:0] status_t;

    // Status codes; ST_NONE doubles as not_found on the output.
    localparam status_t ST_VALID   = 2'd0;
    localparam status_t ST_TRUNC   = 2'd1;
    localparam status_t ST_BAD_CRC = 2'd2;
    localparam status_t ST_NONE    = 2'd3;

    // Element 0 is the oldest byte, the first byte of the candidate.
    typedef logic [HDR_BYTES-1:0][7:0] window_t;

    typedef struct packed {
        logic [63:0] magic_word;
        logic [31:0] image_length;
        logic [31:0] total_size_cap;
    } cfg_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] crc32_header(input window_t win);
        logic [31:0] c;
        c = 32'hFFFFFFFF;
        for (int i = 0; i < CRC_SPAN; i++) begin
            c = crc32_byte(c, win[i]);
        end
        return c ^ 32'hFFFFFFFF;
    endfunction

endpackage

`default_nettype wire

### hdl/chs_judge.sv
// Header candidate check: magic, version, size, flag, total-size bounds and CRC-32.
// Pure combinational; depends on chs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chs_judge (
    input  var chs_pkg::window_t win,
    input  var logic [31:0]      offset,
    input  var chs_pkg::cfg_t    cfg,
    output var chs_pkg::status_t verdict
);
    import chs_pkg::*;

    logic        magic_ok;
    logic        plausible;
    logic [15:0] version;
    logic [15:0] hsize;
    logic [31:0] total;
    logic [31:0] stored_crc;
    logic [31:0] avail;
    logic        truncated;

    always_comb
    begin
        magic_ok = 1'b1;
        for (int k = 0; k < MAGIC_BYTES; k++) begin
            if (win[k] != cfg.magic_word[8*k +: 8]) begin
                magic_ok = 1'b0;
            end
        end
    end

    assign version    = {win[VERSION_AT+1], win[VERSION_AT]};
    assign hsize      = {win[HSIZE_AT+1], win[HSIZE_AT]};
    assign total      = {win[TOTAL_AT+3], win[TOTAL_AT+2], win[TOTAL_AT+1], win[TOTAL_AT]};
    assign stored_crc = {win[CRC_AT+3], win[CRC_AT+2], win[CRC_AT+1], win[CRC_AT]};

    assign plausible = magic_ok && (version == HDR_VERSION)
                    && (hsize == 16'(HDR_BYTES)) && win[FLAGS_AT][0];

    // Past the end of the image no bytes are left at all.
    assign avail = (offset <= cfg.image_length) ? (cfg.image_length - offset) : 32'd0;

    assign truncated = (total > cfg.total_size_cap) || (total > avail)
                    || (total < LEAST_TOTAL);

    always_comb
    begin
        if (!plausible) begin
            verdict = ST_NONE;
        end else if (truncated) begin
            verdict = ST_TRUNC;
        end else if (crc32_header(win) != stored_crc) begin
            verdict = ST_BAD_CRC;
        end else begin
            verdict = ST_VALID;
        end
    end

endmodule

`default_nettype wire

### hdl/container_header_scanner.sv
// Top level of the container header scanner: byte window, scan state and result register.
// Depends on chs_pkg and chs_judge.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted item enters the window register; any result goes to the result register.
// Throughput: one item per cycle unless a held result stalls; the window check and the
// 24-byte CRC are a single combinational stage between the window and result registers.
// Reset (rst_n, asynchronous, active low) clears the scan state and loads the register
// defaults: magic_word 0, image_length 0, total_size_cap 16777216.
module container_header_scanner (
    input  var logic        clk,
    input  var logic        rst_n,
    // Configuration write port.
    input  var logic        cfg_we,
    input  var logic [1:0]  cfg_index,
    input  var logic [63:0] cfg_data,
    // Input stream.
    input  var logic        s_tvalid,
    output var logic        s_tready,
    input  var logic [7:0]  s_tdata,   // data_byte [7:0]
    input  var logic        s_tlast,   // last_byte
    // Result stream.
    output var logic        m_tvalid,
    input  var logic        m_tready,
    output var logic [31:0] m_tdata,   // found_offset [31:0]
    output var logic [1:0]  m_tuser    // scan_status [1:0]
);
    import chs_pkg::*;

    // Configuration registers.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.magic_word     <= '0;
            cfg_reg.image_length   <= '0;
            cfg_reg.total_size_cap <= SIZE_CAP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAGIC:     cfg_reg.magic_word     <= cfg_data;
                REG_IMAGE_LEN: cfg_reg.image_length   <= cfg_data[31:0];
                REG_SIZE_CAP:  cfg_reg.total_size_cap <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // The window register itself is the pending stage: the item that was last accepted
    // is judged while it sits here. The window only shifts when that judgment is taken
    // into the result logic, so a stalled result holds the window as well.
    window_t     window_reg;
    logic [31:0] count_reg;
    logic        pend_valid_reg;
    logic        item_last_reg;   // last_byte of the item most recently accepted

    logic in_fire;
    logic pend_fire;

    assign pend_fire = pend_valid_reg && (!m_tvalid || m_tready);
    assign s_tready  = !pend_valid_reg || !m_tvalid || m_tready;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            window_reg <= {s_tdata, window_reg[HDR_BYTES-1:1]};
        end
    end

    // After the last byte of an image the count restarts, so the next item is byte one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg      <= '0;
            item_last_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                count_reg     <= item_last_reg ? 32'd1 : count_reg + 32'd1;
                item_last_reg <= s_tlast;
            end
            if (in_fire) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_fire) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Candidate check on the current window.
    logic [31:0] offset;
    status_t     verdict;
    logic        window_full;

    assign window_full = count_reg >= 32'(HDR_BYTES);
    assign offset      = count_reg - 32'(HDR_BYTES);

    chs_judge u_judge (
        .win     (window_reg),
        .offset  (offset),
        .cfg     (cfg_reg),
        .verdict (verdict)
    );

    // Scan state across one image.
    logic        reported_reg;
    logic        have_corrupt_reg;
    logic        corrupt_crc_reg;   // 1 bad_crc, 0 truncated
    logic [31:0] corrupt_offset_reg;

    logic        checked;
    logic        found;
    logic        note_corrupt;
    logic        have_corrupt_next;
    logic        corrupt_crc_next;
    logic [31:0] corrupt_offset_next;
    logic        res_valid;
    status_t     res_status;
    logic [31:0] res_offset;

    always_comb
    begin
        checked      = !reported_reg && window_full;
        found        = checked && (verdict == ST_VALID);
        note_corrupt = checked && !have_corrupt_reg
                    && ((verdict == ST_TRUNC) || (verdict == ST_BAD_CRC));

        have_corrupt_next   = have_corrupt_reg || note_corrupt;
        corrupt_crc_next    = note_corrupt ? (verdict == ST_BAD_CRC) : corrupt_crc_reg;
        corrupt_offset_next = note_corrupt ? offset : corrupt_offset_reg;

        // A valid header is reported at once. At the end of the image, unless a valid
        // header was already reported, the first corrupt one (possibly noted on this very
        // byte) is reported, or not_found with offset zero.
        res_valid  = 1'b0;
        res_status = ST_VALID;
        res_offset = offset;
        if (found) begin
            res_valid = 1'b1;
        end else if (item_last_reg && !reported_reg) begin
            res_valid = 1'b1;
            if (have_corrupt_next) begin
                res_status = corrupt_crc_next ? ST_BAD_CRC : ST_TRUNC;
                res_offset = corrupt_offset_next;
            end else begin
                res_status = ST_NONE;
                res_offset = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            reported_reg       <= 1'b0;
            have_corrupt_reg   <= 1'b0;
            corrupt_crc_reg    <= 1'b0;
            corrupt_offset_reg <= '0;
        end else if (pend_fire) begin
            if (item_last_reg) begin
                reported_reg       <= 1'b0;
                have_corrupt_reg   <= 1'b0;
                corrupt_crc_reg    <= 1'b0;
                corrupt_offset_reg <= '0;
            end else begin
                reported_reg       <= reported_reg || found;
                have_corrupt_reg   <= have_corrupt_next;
                corrupt_crc_reg    <= corrupt_crc_next;
                corrupt_offset_reg <= corrupt_offset_next;
            end
        end
    end

    // Result register.
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [31:0] out_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (pend_fire && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_fire && res_valid) begin
            out_status_reg <= res_status;
            out_offset_reg <= res_offset;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_offset_reg;
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire
